>>> hdl/sha1md_pkg.sv
package sha1md_pkg;

   localparam int unsigned NUM_CHAIN   = 5;
   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned ROUNDS      = 80;

   localparam logic [7:0] PAD_MARK        = 8'h80;
   localparam logic [5:0] LEN_SLOT        = 6'd56;
   localparam logic [5:0] LAST_SLOT       = 6'd63;
   localparam logic [2:0] LAST_WORD_INDEX = 3'd4;

   typedef logic [31:0] word_type;

   typedef struct packed {
      logic       start;
      logic       init;
      logic       wr_en;
      logic [3:0] wr_addr;
      word_type   wr_data;
      logic [2:0] rd_index;
   } comp_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } comp_sts_type;

   function automatic word_type init_word(input logic [2:0] idx);
      word_type w;
      unique case (idx)
         3'd0:    w = 32'h67452301;
         3'd1:    w = 32'hEFCDAB89;
         3'd2:    w = 32'h98BADCFE;
         3'd3:    w = 32'h10325476;
         3'd4:    w = 32'hC3D2E1F0;
         default: w = '0;
      endcase
      return w;
   endfunction

   function automatic word_type round_const(input logic [1:0] phase);
      word_type k;
      unique case (phase)
         2'd0: k = 32'h5A827999;
         2'd1: k = 32'h6ED9EBA1;
         2'd2: k = 32'h8F1BBCDC;
         2'd3: k = 32'hCA62C1D6;
      endcase
      return k;
   endfunction

endpackage

>>> hdl/sha1md_compress.sv
module sha1md_compress
   import sha1md_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  comp_ctl_type ctl,
   output comp_sts_type sts,
   output word_type     digest_word
);

   typedef enum logic [2:0] {
      C_IDLE  = 3'b001,
      C_ROUND = 3'b010,
      C_FINAL = 3'b100
   } cstate_type;

   cstate_type state_ff, state_in;
   logic [6:0] round_ff, round_in;
   word_type   chain_ff [NUM_CHAIN];
   word_type   work_ff  [NUM_CHAIN];
   word_type   work_in  [NUM_CHAIN];
   word_type   sched_ff [BLOCK_WORDS];
   word_type   sched_in [BLOCK_WORDS];

   word_type   block_mem [BLOCK_WORDS];
   word_type   rd_data_ff;
   logic [3:0] rd_addr;

   logic [1:0] phase;
   word_type   wt, fv, tv;

   // block buffer: one write port from the byte packer, one read port for the schedule
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         block_mem[ctl.wr_addr] <= ctl.wr_data;
      end
      rd_data_ff <= block_mem[rd_addr];
   end

   always_comb begin
      if (round_ff < 7'd20) begin
         phase = 2'd0;
      end else if (round_ff < 7'd40) begin
         phase = 2'd1;
      end else if (round_ff < 7'd60) begin
         phase = 2'd2;
      end else begin
         phase = 2'd3;
      end
   end

   always_comb begin
      word_type mix;
      mix = sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0];
      if (round_ff < 7'd16) begin
         wt = rd_data_ff;
      end else begin
         wt = {mix[30:0], mix[31]};
      end
   end

   always_comb begin
      unique case (phase)
         2'd0:    fv = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
         2'd2:    fv = (work_ff[1] & work_ff[2]) | (work_ff[1] & work_ff[3])
                     | (work_ff[2] & work_ff[3]);
         default: fv = work_ff[1] ^ work_ff[2] ^ work_ff[3];
      endcase
   end

   assign tv = {work_ff[0][26:0], work_ff[0][31:27]} + fv + work_ff[4]
             + round_const(phase) + wt;

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      rd_addr  = '0;
      work_in  = work_ff;
      sched_in = sched_ff;
      unique case (state_ff)
         C_IDLE: begin
            if (ctl.start) begin
               work_in  = chain_ff;
               round_in = '0;
               state_in = C_ROUND;
            end
         end
         C_ROUND: begin
            rd_addr    = round_ff[3:0] + 4'd1;
            work_in[0] = tv;
            work_in[1] = work_ff[0];
            work_in[2] = {work_ff[1][1:0], work_ff[1][31:2]};
            work_in[3] = work_ff[2];
            work_in[4] = work_ff[3];
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
               sched_in[i] = sched_ff[i + 1];
            end
            sched_in[BLOCK_WORDS - 1] = wt;
            round_in = round_ff + 7'd1;
            if (round_ff == 7'(ROUNDS - 1)) begin
               state_in = C_FINAL;
            end
         end
         C_FINAL: begin
            state_in = C_IDLE;
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         round_ff <= '0;
         for (int i = 0; i < NUM_CHAIN; i++) begin
            chain_ff[i] <= init_word(3'(i));
         end
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         if (ctl.init) begin
            for (int i = 0; i < NUM_CHAIN; i++) begin
               chain_ff[i] <= init_word(3'(i));
            end
         end else if (state_ff == C_FINAL) begin
            for (int i = 0; i < NUM_CHAIN; i++) begin
               chain_ff[i] <= chain_ff[i] + work_ff[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      sched_ff <= sched_in;
   end

   assign sts.busy    = (state_ff != C_IDLE);
   assign sts.done    = (state_ff == C_FINAL);
   assign digest_word = chain_ff[ctl.rd_index];

   a_start_clears_round : assert property (@(posedge clock) disable iff (reset)
      (ctl.start && state_ff == C_IDLE) |=> (state_ff == C_ROUND && round_ff == 7'd0))
      else $error("round count not cleared at block start");

   a_final_after_last_round : assert property (@(posedge clock) disable iff (reset)
      (state_ff == C_FINAL) |-> ($past(state_ff) == C_ROUND
                                 && $past(round_ff) == 7'(ROUNDS - 1)))
      else $error("chain update without full round sequence");

   a_no_start_while_busy : assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> (state_ff == C_IDLE))
      else $error("block start while compression running");

endmodule

>>> hdl/sha1_message_digest.sv
// Input: one byte per cycle while idle; a full block stalls input for the 80 rounds
//   (one per cycle off the block buffer) plus the chain update.
// End of message: padding bytes are added at one per cycle, then one or two compressions
//   and five digest words, one per cycle while the receiver is ready.
// Reset: synchronous, active high; chain words return to the initial values,
//   byte count and length clear, block buffer contents are left as they are.
module sha1_message_digest
   import sha1md_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] byte_valid
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast    // last_word
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_PAD  = 4'b0010,
      S_HASH = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type    state_ff, state_in;
   logic [5:0]   pos_ff, pos_in;
   logic [23:0]  acc_ff, acc_in;
   logic [63:0]  bits_ff, bits_in;
   logic         mark_ff, mark_in;
   logic         lenph_ff, lenph_in;
   logic         last_ff, last_in;
   logic         padding_ff, padding_in;
   logic [2:0]   idx_ff, idx_in;

   logic         put_en;
   logic [7:0]   put_val;
   logic         req_fire, rsp_fire;
   comp_ctl_type ctl;
   comp_sts_type sts;
   word_type     digest_word;

   assign req_fire = req_tvalid & req_tready;
   assign rsp_fire = rsp_tvalid & rsp_tready;

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      acc_in     = acc_ff;
      bits_in    = bits_ff;
      mark_in    = mark_ff;
      lenph_in   = lenph_ff;
      last_in    = last_ff;
      padding_in = padding_ff;
      idx_in     = idx_ff;
      put_en     = 1'b0;
      put_val    = '0;
      ctl        = '0;
      ctl.rd_index = idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_tuser) begin
                  put_en  = 1'b1;
                  put_val = req_tdata;
                  bits_in = bits_ff + 64'd8;
               end
               if (req_tlast) begin
                  padding_in = 1'b1;
               end
               if (req_tuser && pos_ff == LAST_SLOT) begin
                  state_in = S_HASH;
               end else if (req_tlast) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            put_en  = 1'b1;
            mark_in = 1'b1;
            if (!mark_ff) begin
               put_val = PAD_MARK;
            end else if (lenph_ff || pos_ff == LEN_SLOT) begin
               put_val  = bits_ff[63:56];
               bits_in  = {bits_ff[55:0], 8'h00};
               lenph_in = 1'b1;
               if (pos_ff == LAST_SLOT) begin
                  last_in = 1'b1;
               end
            end else begin
               put_val = '0;
            end
            if (pos_ff == LAST_SLOT) begin
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (sts.done) begin
               if (last_ff) begin
                  state_in = S_OUT;
               end else if (padding_ff) begin
                  state_in = S_PAD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_OUT: begin
            if (rsp_fire) begin
               if (idx_ff == LAST_WORD_INDEX) begin
                  ctl.init   = 1'b1;
                  pos_in     = '0;
                  bits_in    = '0;
                  mark_in    = 1'b0;
                  lenph_in   = 1'b0;
                  last_in    = 1'b0;
                  padding_in = 1'b0;
                  idx_in     = '0;
                  state_in   = S_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // big-endian packing; whole word goes to the buffer on its fourth byte
      if (put_en) begin
         acc_in = {acc_ff[15:0], put_val};
         pos_in = pos_ff + 6'd1;
         if (pos_ff[1:0] == 2'd3) begin
            ctl.wr_en   = 1'b1;
            ctl.wr_addr = pos_ff[5:2];
            ctl.wr_data = {acc_ff, put_val};
         end
         if (pos_ff == LAST_SLOT) begin
            ctl.start = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         pos_ff     <= '0;
         bits_ff    <= '0;
         mark_ff    <= 1'b0;
         lenph_ff   <= 1'b0;
         last_ff    <= 1'b0;
         padding_ff <= 1'b0;
         idx_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         bits_ff    <= bits_in;
         mark_ff    <= mark_in;
         lenph_ff   <= lenph_in;
         last_ff    <= last_in;
         padding_ff <= padding_in;
         idx_ff     <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   sha1md_compress u_compress (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .sts         (sts),
      .digest_word (digest_word)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = digest_word;
   assign rsp_tuser  = idx_ff;
   assign rsp_tlast  = (idx_ff == LAST_WORD_INDEX);

   a_no_write_during_rounds : assert property (@(posedge clock) disable iff (reset)
      ctl.wr_en |-> !sts.busy)
      else $error("block buffer written while compression reads it");

   a_word_index_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> (idx_ff <= LAST_WORD_INDEX))
      else $error("digest word index out of range");

   a_final_block_has_length : assert property (@(posedge clock) disable iff (reset)
      last_ff |-> (lenph_ff && mark_ff && padding_ff))
      else $error("final block flagged without padding and length");

endmodule

>>> tb/testbench.sv
module testbench;
   import sha1md_pkg::*;

   localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
   localparam logic [159:0] ABC_DIGEST   = 160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

   localparam logic [31:0] SHA_IV [5] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                          32'h10325476, 32'hC3D2E1F0};
   localparam logic [31:0] SHA_K [4]  = '{32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC,
                                          32'hCA62C1D6};

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   typedef struct packed {
      logic [7:0]   data;
      logic         byte_valid;
      logic         end_mark;
      logic         known;
      logic [159:0] digest;
   } stim_row_type;

   localparam int NUM_ROWS = 13;
   localparam stim_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},   // empty message
      '{8'h5a, 1'b0, 1'b0, 1'b0, 160'h0},         // ignored
      '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
      '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
      '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},     // end on the last byte
      '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
      '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
      '{8'h63, 1'b1, 1'b0, 1'b0, 160'h0},
      '{8'h00, 1'b0, 1'b1, 1'b1, ABC_DIGEST},     // bare end marker
      '{8'hff, 1'b1, 1'b1, 1'b0, 160'h0},
      '{8'h00, 1'b1, 1'b1, 1'b0, 160'h0},
      '{8'hff, 1'b0, 1'b0, 1'b0, 160'h0},
      '{8'hff, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST}    // data ignored on bare marker
   };

   localparam int NUM_SPECIAL = 2;
   localparam int SPECIAL_LENGTHS [NUM_SPECIAL] = '{56, 64};

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   logic [31:0]     hash_state [5];
   logic [31:0]     msg_block [16];
   logic [5:0]      block_fill;
   logic [63:0]     msg_bit_count;
   digest_word_type expected_words [$];
   digest_word_type expected_head;
   int              mismatch_count = 0;
   int              request_count = 0;
   bit              hold_wanted = 1'b0;
   bit              hold_done = 1'b0;

   sha1_message_digest u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic void restart_hash();
      for (int i = 0; i < 5; i++) hash_state[i] = SHA_IV[i];
      block_fill    = '0;
      msg_bit_count = '0;
   endfunction

   function automatic void compress_block();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, t, x;
      for (int i = 0; i < 16; i++) w[i] = msg_block[i];
      a = hash_state[0];
      b = hash_state[1];
      c = hash_state[2];
      d = hash_state[3];
      e = hash_state[4];
      for (int r = 0; r < 80; r++) begin
         if (r >= 16) begin
            x = w[(r + 13) & 15] ^ w[(r + 8) & 15] ^ w[(r + 2) & 15] ^ w[r & 15];
            w[r & 15] = {x[30:0], x[31]};
         end
         case (r / 20)
            0: f = (b & c) | (~b & d);
            2: f = (b & c) | (b & d) | (c & d);
            default: f = b ^ c ^ d;
         endcase
         k = SHA_K[r / 20];
         t = {a[26:0], a[31:27]} + f + e + k + w[r & 15];
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = t;
      end
      hash_state[0] += a;
      hash_state[1] += b;
      hash_state[2] += c;
      hash_state[3] += d;
      hash_state[4] += e;
   endfunction

   function automatic void absorb_byte(logic [7:0] value);
      logic [31:0] shifted;
      shifted = {24'h0, value} << ((3 - block_fill[1:0]) * 8);
      if (block_fill[1:0] == 2'd0) msg_block[block_fill[5:2]] = shifted;
      else msg_block[block_fill[5:2]] |= shifted;
      if (block_fill == LAST_SLOT) begin
         compress_block();
         block_fill = '0;
      end else begin
         block_fill = block_fill + 6'd1;
      end
   endfunction

   // returns 1 when the request closes a message, with its digest
   function automatic bit predict_digest(logic [7:0] data, bit valid, bit eom,
                                         output logic [159:0] digest);
      logic [63:0] total_bits;
      digest = '0;
      if (valid) begin
         absorb_byte(data);
         msg_bit_count += 64'd8;
      end
      if (!eom) return 1'b0;
      total_bits = msg_bit_count;
      absorb_byte(PAD_MARK);
      while (block_fill != LEN_SLOT) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(total_bits[63 - 8 * i -: 8]);
      digest = {hash_state[0], hash_state[1], hash_state[2], hash_state[3], hash_state[4]};
      restart_hash();
      return 1'b1;
   endfunction

   task automatic idle_gap(input bit steady);
      int pick;
      int gap;
      pick = $urandom_range(0, 19);
      if (steady || pick < 12) gap = 0;
      else if (pick < 18) gap = $urandom_range(1, 3);
      else gap = $urandom_range(15, 50);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_request(input logic [7:0] data, input bit valid, input bit eom,
                               input bit steady, input bit known,
                               input logic [159:0] known_digest);
      logic [159:0] digest;
      digest_word_type item;
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= valid;
      req_tlast  <= eom;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (valid || eom) request_count++;
      if (predict_digest(data, valid, eom, digest)) begin
         if (known) digest = known_digest;
         for (int i = 0; i < 5; i++) begin
            item.word  = digest[159 - 32 * i -: 32];
            item.index = i[2:0];
            item.last  = (i[2:0] == LAST_WORD_INDEX);
            expected_words.push_back(item);
         end
      end
      idle_gap(steady);
   endtask

   task automatic send_message(input int length);
      bit steady;
      bit bare;
      steady = ($urandom_range(0, 4) == 0);
      bare   = (length == 0) || ($urandom_range(0, 1) == 1);
      for (int i = 0; i < length; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0, steady, 1'b0, '0);
         send_request(8'($urandom_range(0, 255)), 1'b1, !bare && (i == length - 1),
                      steady, 1'b0, '0);
      end
      if (bare) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1, steady, 1'b0, '0);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected digest word %h index %0d last %b", $time,
                     rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            expected_head = expected_words.pop_front();
            if (rsp_tdata !== expected_head.word) begin
               mismatch_count++;
               $display("%0t: digest_word expected %h actual %h", $time,
                        expected_head.word, rsp_tdata);
            end
            if (rsp_tuser !== expected_head.index) begin
               mismatch_count++;
               $display("%0t: word_index expected %0d actual %0d", $time,
                        expected_head.index, rsp_tuser);
            end
            if (rsp_tlast !== expected_head.last) begin
               mismatch_count++;
               $display("%0t: last_word expected %b actual %b", $time,
                        expected_head.last, rsp_tlast);
            end
         end
      end
   end

   // receiver: random ready bursts, one long hold-off when asked
   initial begin
      int pick;
      int span;
      logic ready_value;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_wanted && !hold_done) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (600) @(posedge clock);
         end else begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
               ready_value = 1'b1;
               span = $urandom_range(1, 20);
            end else if (pick < 8) begin
               ready_value = 1'b0;
               span = $urandom_range(1, 3);
            end else if (pick < 9) begin
               ready_value = 1'b0;
               span = $urandom_range(20, 60);
            end else begin
               ready_value = 1'b1;
               span = $urandom_range(50, 150);
            end
            rsp_tready <= ready_value;
            repeat (span) @(posedge clock);
         end
      end
   end

   initial begin
      int start_count;
      int messages;
      int drain_wait;
      restart_hash();
      for (int i = 0; i < 16; i++) msg_block[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_ROWS; i++)
         send_request(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].byte_valid,
                      DIRECTED_ROWS[i].end_mark, 1'b0, DIRECTED_ROWS[i].known,
                      DIRECTED_ROWS[i].digest);
      wait_drained();

      // leftovers that force an extra padding block
      for (int i = 0; i < NUM_SPECIAL; i++) send_message(SPECIAL_LENGTHS[i]);
      wait_drained();

      // keep offering while the receiver holds off
      hold_wanted = 1'b1;
      while (!hold_done) @(posedge clock);
      start_count = request_count;
      messages = 0;
      while (request_count - start_count < 20 || messages < 6) begin
         if ($urandom_range(0, 9) == 0) send_message($urandom_range(13, 40));
         else send_message($urandom_range(0, 12));
         messages++;
      end
      req_tvalid <= 1'b0;

      drain_wait = 0;
      while (expected_words.size() != 0 && drain_wait < 50000) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("sha1_message_digest test passed");
      end else begin
         $display("sha1_message_digest test failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("sha1_message_digest test failed");
      $finish;
   end

endmodule
